>>> rtl/core/dxtd_pkg.sv
// ----------------------------------------------------------------------------
// DXT block decoder package
// Shared types, format codes and fixed-ratio arithmetic helpers.
// ----------------------------------------------------------------------------
package dxtd_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  localparam int TEXELS = 4 * 4;
  localparam int IDX_W = $clog2(TEXELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TEXELS - 1);

  typedef struct packed {
    logic [63:0]      alpha_half;
    logic [63:0]      color_half;
    fmt_t             fmt;
    logic [IDX_W-1:0] idx;
  } blk_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [IDX_W-1:0] texel_index;
    logic             last_texel;
    logic             punch_through;
  } texel_t;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] cnt;
    logic             adv;
  } blk_stat_t;

  // v * 255 / 31, truncating, by reciprocal multiplication.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] x;
    logic [26:0] p;
    x = 13'(v) * 13'd255;
    p = 27'(x) * 27'd8457;
    return p[25:18];
  endfunction

  // v * 255 / 63, truncating.
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] x;
    logic [28:0] p;
    x = 14'(v) * 14'd255;
    p = 29'(x) * 29'd16645;
    return p[27:20];
  endfunction

  // x / 3 for x up to 765.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'd43691;
    return p[24:17];
  endfunction

  // x / 7 for x up to 1785.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd4682;
    return p[22:15];
  endfunction

  // x / 5 for x up to 1275.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

endpackage

>>> rtl/core/dxtd_block_if.sv
// ----------------------------------------------------------------------------
// DXT block channel
// Carries one compressed block per beat as two 64-bit halves.
// ----------------------------------------------------------------------------
interface dxtd_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_half;
  logic [63:0] color_half;

  modport source (output valid, output alpha_half, output color_half, input ready);
  modport sink (input valid, input alpha_half, input color_half, output ready);
endinterface

>>> rtl/core/dxtd_texel_if.sv
// ----------------------------------------------------------------------------
// DXT texel channel
// Carries one decoded RGBA8 texel per beat with its position in the block.
// ----------------------------------------------------------------------------
interface dxtd_texel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [3:0] texel_index;
  logic       last_texel;
  logic       punch_through;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output texel_index, output last_texel, output punch_through,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input texel_index, input last_texel, input punch_through,
                output ready);
endinterface

>>> rtl/core/dxtd_cfg_if.sv
// ----------------------------------------------------------------------------
// DXT configuration channel
// Write channel for the block format register.
// ----------------------------------------------------------------------------
interface dxtd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] block_format;

  modport source (output valid, output block_format, input ready);
  modport sink (input valid, input block_format, output ready);
endinterface

>>> rtl/core/dxtd_block_reg.sv
// ----------------------------------------------------------------------------
// DXT block register
// Holds the current block and steps the texel counter through it.
// ----------------------------------------------------------------------------
module dxtd_block_reg
  import dxtd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  dxtd_block_if.sink      in_blk,
  input  fmt_t            fmt,
  input  logic            out_free,
  output blk_t            blk,
  output blk_stat_t       stat
);

  logic             busy_r;
  logic [IDX_W-1:0] cnt_r;
  logic [63:0]      alpha_r;
  logic [63:0]      color_r;
  fmt_t             fmt_r;
  logic             last;
  logic             adv;
  logic             take;

  assign last = (cnt_r == LAST_IDX);
  assign adv = busy_r && out_free;
  assign in_blk.ready = !busy_r || (adv && last);
  assign take = in_blk.valid && in_blk.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (adv) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      alpha_r <= in_blk.alpha_half;
      color_r <= in_blk.color_half;
      fmt_r   <= fmt;
    end
  end

  assign blk = '{alpha_half: alpha_r, color_half: color_r, fmt: fmt_r, idx: cnt_r};
  assign stat = '{busy: busy_r, cnt: cnt_r, adv: adv};

endmodule

>>> rtl/core/dxtd_texel_decode.sv
// ----------------------------------------------------------------------------
// DXT texel decoder
// Computes the color and alpha of the selected texel of the held block.
// ----------------------------------------------------------------------------
module dxtd_texel_decode
  import dxtd_pkg::*;
(
  input  blk_t   blk,
  output texel_t texel
);

  logic [15:0] c0;
  logic [15:0] c1;
  logic [31:0] codes;
  logic [1:0]  ci;
  logic [47:0] abits;
  logic [5:0]  aoff;
  logic [2:0]  ai;
  logic [3:0]  nib;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic        dxt1;
  logic        three;
  logic [7:0]  e0 [3];
  logic [7:0]  e1 [3];
  logic [7:0]  col [3];
  logic [7:0]  col_alpha;
  logic [7:0]  a5;
  logic [2:0]  w0;
  logic [2:0]  w1;
  logic [10:0] asum;
  logic [7:0]  alpha;

  assign c0 = blk.color_half[15:0];
  assign c1 = blk.color_half[31:16];
  assign codes = blk.color_half[63:32];
  assign ci = codes[{blk.idx, 1'b0} +: 2];
  assign abits = blk.alpha_half[63:16];
  assign aoff = 6'(blk.idx) * 6'd3;
  assign ai = abits[aoff +: 3];
  assign nib = blk.alpha_half[{blk.idx, 2'b00} +: 4];
  assign a0 = blk.alpha_half[7:0];
  assign a1 = blk.alpha_half[15:8];

  assign dxt1 = (blk.fmt == FMT_DXT1) || (blk.fmt == FMT_RSVD);
  assign three = dxt1 && !(c0 > c1);

  assign e0[0] = expand5(c0[15:11]);
  assign e0[1] = expand6(c0[10:5]);
  assign e0[2] = expand5(c0[4:0]);
  assign e1[0] = expand5(c1[15:11]);
  assign e1[1] = expand6(c1[10:5]);
  assign e1[2] = expand5(c1[4:0]);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      unique case (ci)
        2'd0: col[ch] = e0[ch];
        2'd1: col[ch] = e1[ch];
        2'd2: col[ch] = three ? 8'((9'(e0[ch]) + 9'(e1[ch])) >> 1)
                              : div3(10'({e0[ch], 1'b0}) + 10'(e1[ch]));
        default: col[ch] = three ? 8'd0 : div3(10'(e0[ch]) + 10'({e1[ch], 1'b0}));
      endcase
    end
  end

  assign col_alpha = (three && ci == 2'd3) ? 8'd0 : 8'd255;

  always_comb begin
    w0 = 3'(4'd8 - 4'(ai));
    w1 = ai - 3'd1;
    if (!(a0 > a1)) begin
      w0 = 3'(4'd6 - 4'(ai));
    end
    asum = 11'(a0) * 11'(w0) + 11'(a1) * 11'(w1);
    priority if (ai == 3'd0) begin
      a5 = a0;
    end else if (ai == 3'd1) begin
      a5 = a1;
    end else if (a0 > a1) begin
      a5 = div7(asum);
    end else if (ai == 3'd6) begin
      a5 = 8'd0;
    end else if (ai == 3'd7) begin
      a5 = 8'd255;
    end else begin
      a5 = div5(asum);
    end
  end

  always_comb begin
    unique case (blk.fmt)
      FMT_DXT3: alpha = {nib, nib};
      FMT_DXT5: alpha = a5;
      default:  alpha = col_alpha;
    endcase
  end

  assign texel = '{red: col[0], green: col[1], blue: col[2], alpha: alpha,
                   texel_index: blk.idx, last_texel: (blk.idx == LAST_IDX),
                   punch_through: three};

endmodule

>>> rtl/core/dxtd_out_reg.sv
// ----------------------------------------------------------------------------
// DXT output register
// Holds one decoded texel until the sink takes the beat.
// ----------------------------------------------------------------------------
module dxtd_out_reg
  import dxtd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  texel_t        texel,
  dxtd_texel_if.source  out_texel,
  output logic          free
);

  logic   valid_r;
  texel_t data_r;

  assign free = !valid_r || out_texel.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_texel.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= texel;
    end
  end

  assign out_texel.valid = valid_r;
  assign out_texel.red = data_r.red;
  assign out_texel.green = data_r.green;
  assign out_texel.blue = data_r.blue;
  assign out_texel.alpha = data_r.alpha;
  assign out_texel.texel_index = data_r.texel_index;
  assign out_texel.last_texel = data_r.last_texel;
  assign out_texel.punch_through = data_r.punch_through;

endmodule

>>> rtl/core/dxt_texture_block_decoder.sv
// ----------------------------------------------------------------------------
// DXT texture block decoder
// Decodes DXT1, DXT3 and DXT5 blocks into sixteen RGBA8 texels in row order.
// ----------------------------------------------------------------------------
// A block is taken in one beat and leaves as sixteen texel beats, one per
// cycle while the output register is free to take them; the texel counter
// steps the single decode path through the held block. The next block is
// accepted in the same cycle that the last texel of the current one moves to
// the output register, so blocks follow without a gap. An accepted block is
// captured in the block register and each texel then passes through the
// output register. The format register is sampled when a block is accepted.
module dxt_texture_block_decoder
  import dxtd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  dxtd_cfg_if.sink      cfg_wr,
  dxtd_block_if.sink    in_blk,
  dxtd_texel_if.source  out_texel
);

  fmt_t      fmt_r;
  blk_t      blk;
  blk_stat_t stat;
  texel_t    texel;
  logic      out_free;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DXT1;
    end else if (cfg_wr.valid) begin
      fmt_r <= fmt_t'(cfg_wr.block_format);
    end
  end

  dxtd_block_reg u_block_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_blk   (in_blk),
    .fmt      (fmt_r),
    .out_free (out_free),
    .blk      (blk),
    .stat     (stat)
  );

  dxtd_texel_decode u_decode (
    .blk   (blk),
    .texel (texel)
  );

  dxtd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stat.adv),
    .texel     (texel),
    .out_texel (out_texel),
    .free      (out_free)
  );

  a_take_starts_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_blk.valid && in_blk.ready |=> stat.busy && stat.cnt == '0)
    else $error("accepted block did not start at texel zero");

  a_ready_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_blk.ready |-> !stat.busy || (stat.adv && stat.cnt == LAST_IDX))
    else $error("block accepted while texels of the held block remain");

  a_adv_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    stat.adv |=> out_texel.valid)
    else $error("advanced texel did not reach the output register");

  a_no_adv_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_texel.valid && !out_texel.ready |-> !stat.adv)
    else $error("texel overwrote a stalled output beat");

endmodule
